FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the convolution block. Each macro
// expects signals named clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

FILE: design/conv3_pkg.sv
// ----------------------------------------------------------------------------
// conv3_pkg
// Shared constants, register codes and pipeline control type of the 3x3
// streaming convolution block.
// ----------------------------------------------------------------------------
package conv3_pkg;

	// Default geometry and number formats.
	localparam int IMAGE_WIDTH_DEF  = 28;
	localparam int IMAGE_HEIGHT_DEF = 28;
	localparam int PIXEL_BITS_DEF   = 8;
	localparam int COEF_BITS_DEF    = 16;

	// Kernel window size, fixed by the scheme.
	localparam int KERNEL_TAPS = 9;

	// Configuration register index width and codes.
	localparam int CFG_INDEX_BITS = 2;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_KERNEL_ROW_TOP    = 2'd0,
		REG_KERNEL_ROW_MID    = 2'd1,
		REG_KERNEL_ROW_BOTTOM = 2'd2
	} cfg_reg_t;

	// Control that travels with a window through the arithmetic pipeline.
	typedef struct packed {
		logic valid;
		logic last;
	} ctl_t;

endpackage

FILE: design/conv3_ram.sv
// ----------------------------------------------------------------------------
// conv3_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module conv3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 28
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the output holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/conv3_window.sv
// ----------------------------------------------------------------------------
// conv3_window
// Position counters, line store read-modify-write and the 3x3 pixel window.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module conv3_window #(
	parameter int IMAGE_WIDTH  = conv3_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = conv3_pkg::IMAGE_HEIGHT_DEF,
	parameter int PIXEL_BITS   = conv3_pkg::PIXEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic                  pix_valid,
	input  logic [PIXEL_BITS-1:0] pixel,
	input  logic                  start_of_image,
	output logic [PIXEL_BITS-1:0] win [conv3_pkg::KERNEL_TAPS],
	output conv3_pkg::ctl_t       ctl_s2
);

	localparam int COL_BITS  = $clog2(IMAGE_WIDTH);
	localparam int ROW_BITS  = $clog2(IMAGE_HEIGHT);
	localparam int LINE_BITS = 2 * PIXEL_BITS;

	logic                  accept;
	logic [COL_BITS-1:0]   col_q, cur_col;
	logic [ROW_BITS-1:0]   row_q, cur_row;

	logic                  valid_s1;
	logic                  emit_s1;
	logic                  last_s1;
	logic [COL_BITS-1:0]   col_s1;
	logic [PIXEL_BITS-1:0] pixel_s1;

	logic [LINE_BITS-1:0]  ram_rdata, line_col, wr_data;
	logic [PIXEL_BITS-1:0] top_px, mid_px;
	logic                  ram_we;
	logic                  fwd_sel_q;
	logic [LINE_BITS-1:0]  fwd_q;

	logic [PIXEL_BITS-1:0] win_q [conv3_pkg::KERNEL_TAPS];

	assign accept = pix_valid && advance;

	// Position of the incoming pixel; start of image restarts at the origin.
	assign cur_col = start_of_image ? '0 : col_q;
	assign cur_row = start_of_image ? '0 : row_q;

	// Position counters point at the next expected pixel and wrap per image.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (cur_col == COL_BITS'(IMAGE_WIDTH - 1)) begin
				col_q <= '0;
				if (cur_row == ROW_BITS'(IMAGE_HEIGHT - 1)) begin
					row_q <= '0;
				end else begin
					row_q <= cur_row + ROW_BITS'(1);
				end
			end else begin
				col_q <= cur_col + COL_BITS'(1);
				row_q <= cur_row;
			end
		end
	end

	// Stage 1 holds the pixel while the line store read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixel;
			col_s1   <= cur_col;
			emit_s1  <= (cur_row >= ROW_BITS'(2)) && (cur_col >= COL_BITS'(2));
			last_s1  <= (cur_row == ROW_BITS'(IMAGE_HEIGHT - 1)) &&
			            (cur_col == COL_BITS'(IMAGE_WIDTH - 1));
		end
	end

	// Both line stores share one entry per column: upper half is two rows back.
	conv3_ram #(
		.WIDTH (LINE_BITS),
		.DEPTH (IMAGE_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s1),
		.wdata (wr_data),
		.re    (accept),
		.raddr (cur_col),
		.rdata (ram_rdata)
	);

	assign line_col = fwd_sel_q ? fwd_q : ram_rdata;
	assign top_px   = line_col[LINE_BITS-1:PIXEL_BITS];
	assign mid_px   = line_col[PIXEL_BITS-1:0];
	assign wr_data  = {mid_px, pixel_s1};
	assign ram_we   = valid_s1 && advance;

	// Forward a write that lands on the column being read in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_sel_q <= 1'b0;
		end else if (advance) begin
			fwd_sel_q <= accept && valid_s1 && (cur_col == col_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fwd_q <= wr_data;
		end
	end

	// The window shifts left by one column and takes the new column on the right.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < conv3_pkg::KERNEL_TAPS; i++) begin
				win_q[i] <= '0;
			end
		end else if (advance && valid_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]     <= win_q[r*3 + 1];
				win_q[r*3 + 1] <= win_q[r*3 + 2];
			end
			win_q[2] <= top_px;
			win_q[5] <= mid_px;
			win_q[8] <= pixel_s1;
		end
	end

	assign win = win_q;

	// Control of the window now in place.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (advance) begin
			ctl_s2.valid <= valid_s1 && emit_s1;
			ctl_s2.last  <= last_s1;
		end
	end

	`ASSERT_CLK(a_sof_origin, accept && start_of_image |=> col_s1 == '0, "start of image did not restart the column")
	`ASSERT_NEVER(a_fwd_orphan, fwd_sel_q && !valid_s1, "forwarding selected with no pixel in stage 1")
	`ASSERT_NEVER(a_col_range, col_q > COL_BITS'(IMAGE_WIDTH - 1), "column counter beyond the image width")

endmodule

FILE: design/conv3_mac.sv
// ----------------------------------------------------------------------------
// conv3_mac
// Multiply-accumulate pipeline: nine products, row sums, total and the
// output register.
// ----------------------------------------------------------------------------
module conv3_mac #(
	parameter int PIXEL_BITS = conv3_pkg::PIXEL_BITS_DEF,
	parameter int COEF_BITS  = conv3_pkg::COEF_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                advance,
	input  logic [PIXEL_BITS-1:0]               win [conv3_pkg::KERNEL_TAPS],
	input  conv3_pkg::ctl_t                     ctl_s2,
	input  logic [3*COEF_BITS-1:0]              kernel [3],
	output logic                                res_valid,
	output logic signed [PIXEL_BITS+COEF_BITS+3:0] conv_sum,
	output logic                                last_of_image
);

	localparam int PROD_BITS = PIXEL_BITS + COEF_BITS;
	localparam int ROW_BITS  = PROD_BITS + 2;
	localparam int SUM_BITS  = PROD_BITS + 4;

	logic signed [PROD_BITS:0]   prod_wide [conv3_pkg::KERNEL_TAPS];
	logic signed [PROD_BITS-1:0] prod_s3   [conv3_pkg::KERNEL_TAPS];
	logic signed [ROW_BITS-1:0]  row_sum   [3];
	logic signed [ROW_BITS-1:0]  rsum_s4   [3];
	logic signed [SUM_BITS-1:0]  total;
	conv3_pkg::ctl_t             ctl_s3, ctl_s4;

	// Nine independent products of an unsigned pixel with a signed coefficient.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_wide[r*3 + c] = $signed({1'b0, win[r*3 + c]}) *
				                     $signed(kernel[r][c*COEF_BITS +: COEF_BITS]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < conv3_pkg::KERNEL_TAPS; i++) begin
				prod_s3[i] <= prod_wide[i][PROD_BITS-1:0];
			end
		end
	end

	// Sum of each kernel row.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			row_sum[r] = ROW_BITS'(prod_s3[r*3]) + ROW_BITS'(prod_s3[r*3 + 1]) +
			             ROW_BITS'(prod_s3[r*3 + 2]);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsum_s4 <= row_sum;
		end
	end

	assign total = SUM_BITS'(rsum_s4[0]) + SUM_BITS'(rsum_s4[1]) + SUM_BITS'(rsum_s4[2]);

	// Control follows the data through the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3    <= '0;
			ctl_s4    <= '0;
			res_valid <= 1'b0;
		end else if (advance) begin
			ctl_s3    <= ctl_s2;
			ctl_s4    <= ctl_s3;
			res_valid <= ctl_s4.valid;
		end
	end

	// Output register holds the result until the transfer completes.
	always_ff @(posedge clk) begin
		if (advance) begin
			conv_sum      <= total;
			last_of_image <= ctl_s4.last;
		end
	end

endmodule

FILE: design/conv3x3_valid_stream_unit.sv
// ----------------------------------------------------------------------------
// conv3x3_valid_stream_unit
// Streaming 3x3 valid-mode convolution of a raster-order grayscale image.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter in raster order on the pixel channel (pix_valid, pix_stall),
// one transfer per pixel; start_of_image on a pixel restarts the position
// counters at row 0, column 0. Counters also wrap after the last pixel.
// Every pixel at row two or more and column two or more gives one result on
// the result channel (res_valid, res_stall): the signed integer dot product of
// the 3x3 window with the kernel, with last_of_image set on the final one.
// The kernel rows are written through the configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data), always ready; the user must write them only
// while idle, which the block does not enforce. Throughput is one pixel per
// cycle unless the result channel stalls: the line store RAM is read for one
// column and written back for the previous one in each such cycle, with a bypass
// when both hit the same column. Results pass through the window, product, row
// sum and output registers. Reset clears counters, window, kernel and pipeline
// valids; the line store needs no clearing. While the result register is full
// and stalled, the whole pipeline holds and pix_stall is raised.
// ----------------------------------------------------------------------------
module conv3x3_valid_stream_unit #(
	parameter int IMAGE_WIDTH  = conv3_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = conv3_pkg::IMAGE_HEIGHT_DEF,
	parameter int PIXEL_BITS   = conv3_pkg::PIXEL_BITS_DEF,
	parameter int COEF_BITS    = conv3_pkg::COEF_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   pix_valid,
	output logic                                   pix_stall,
	input  logic [PIXEL_BITS-1:0]                  pixel,
	input  logic                                   start_of_image,
	output logic                                   res_valid,
	input  logic                                   res_stall,
	output logic signed [PIXEL_BITS+COEF_BITS+3:0] conv_sum,
	output logic                                   last_of_image,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [conv3_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [3*COEF_BITS-1:0]                 cfg_data
);

	logic                  advance;
	logic [PIXEL_BITS-1:0] win [conv3_pkg::KERNEL_TAPS];
	conv3_pkg::ctl_t       ctl_s2;
	logic [3*COEF_BITS-1:0] kernel_q [3];

	// The pipeline moves whenever the output register is free or being taken.
	assign advance   = !res_valid || !res_stall;
	assign pix_stall = !advance;
	assign cfg_ready = 1'b1;

	// Kernel row registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				kernel_q[r] <= '0;
			end
		end else if (cfg_valid) begin
			case (conv3_pkg::cfg_reg_t'(cfg_index))
				conv3_pkg::REG_KERNEL_ROW_TOP: begin
					kernel_q[0] <= cfg_data;
				end
				conv3_pkg::REG_KERNEL_ROW_MID: begin
					kernel_q[1] <= cfg_data;
				end
				conv3_pkg::REG_KERNEL_ROW_BOTTOM: begin
					kernel_q[2] <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	conv3_window #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT),
		.PIXEL_BITS   (PIXEL_BITS)
	) u_window (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.pix_valid      (pix_valid),
		.pixel          (pixel),
		.start_of_image (start_of_image),
		.win            (win),
		.ctl_s2         (ctl_s2)
	);

	conv3_mac #(
		.PIXEL_BITS (PIXEL_BITS),
		.COEF_BITS  (COEF_BITS)
	) u_mac (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.win           (win),
		.ctl_s2        (ctl_s2),
		.kernel        (kernel_q),
		.res_valid     (res_valid),
		.conv_sum      (conv_sum),
		.last_of_image (last_of_image)
	);

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking regression for the streaming 3x3 valid-mode convolution.
// A clocked driver offers pixels from a feed queue in random bursts. A
// clocked monitor applies its own stall pattern and checks every result
// against a bit-true prediction of the window sum and the end-of-image flag.
// Kernel settings run from the most negative to the most positive and go on
// to random ones. One full image is split across four settings and wraps
// into the next image without a start mark. A long receiver hold backs the
// pipeline up into the pixel input.
// ----------------------------------------------------------------------------
module tb;

	localparam int IMG_W     = conv3_pkg::IMAGE_WIDTH_DEF;
	localparam int IMG_H     = conv3_pkg::IMAGE_HEIGHT_DEF;
	localparam int PIX_BITS  = conv3_pkg::PIXEL_BITS_DEF;
	localparam int COEF_BITS = conv3_pkg::COEF_BITS_DEF;
	localparam int SUM_BITS  = conv3_pkg::PIXEL_BITS_DEF + conv3_pkg::COEF_BITS_DEF + 4;
	localparam int ROW_BITS  = 3 * conv3_pkg::COEF_BITS_DEF;

	localparam int CLK_PERIOD       = 10;
	localparam int LIMIT_CYCLES     = 200000;
	localparam int SETTLE_CYCLES    = 12;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int MAX_PRINTED      = 40;

	// Register index outside the kernel map; a write to it must change nothing.
	localparam logic [conv3_pkg::CFG_INDEX_BITS-1:0] CFG_INDEX_UNUSED = 2'd3;

	localparam logic [COEF_BITS-1:0] COEF_MOST_NEG  = 16'h8000;
	localparam logic [COEF_BITS-1:0] COEF_MOST_POS  = 16'h7fff;
	localparam logic [COEF_BITS-1:0] COEF_MINUS_ONE = 16'hffff;

	typedef enum {PX_RANDOM, PX_BRIGHT} px_mode_t;

	typedef struct packed {
		logic [PIX_BITS-1:0] value;
		logic                sop;
	} pixel_item_t;

	typedef struct packed {
		logic [SUM_BITS-1:0] sum;
		logic                last;
	} window_sum_t;

	logic                                  clk;
	logic                                  arst_n         = 1'b0;
	logic                                  pix_valid      = 1'b0;
	logic                                  pix_stall;
	logic [PIX_BITS-1:0]                   pixel          = '0;
	logic                                  start_of_image = 1'b0;
	logic                                  res_valid;
	logic                                  res_stall      = 1'b0;
	logic signed [SUM_BITS-1:0]            conv_sum;
	logic                                  last_of_image;
	logic                                  cfg_valid      = 1'b0;
	logic                                  cfg_ready;
	logic [conv3_pkg::CFG_INDEX_BITS-1:0]  cfg_index      = '0;
	logic [ROW_BITS-1:0]                   cfg_data       = '0;

	// Pixels waiting to be offered, and window sums waiting to arrive.
	pixel_item_t pixel_feed [$];
	window_sum_t pending_sums [$];

	// Own copy of the kernel, line stores, window and raster position.
	logic [ROW_BITS-1:0] kernel_copy [3]     = '{default: '0};
	logic [PIX_BITS-1:0] store_upper [IMG_W] = '{default: '0};
	logic [PIX_BITS-1:0] store_lower [IMG_W] = '{default: '0};
	logic [PIX_BITS-1:0] window_px [3][3]    = '{default: '0};
	int                  col_pos = 0;
	int                  row_pos = 0;

	int          mismatch_count = 0;
	int          pixels_sent    = 0;
	int          results_seen   = 0;
	int          input_stalls   = 0;
	bit          steady_flow    = 1'b0;
	int unsigned hold_requests  = 0;
	int unsigned hold_served    = 0;
	int unsigned hold_left      = 0;
	int          burst_left     = 0;
	int          gap_left       = 0;
	int          flow_left      = 0;
	int          stall_left     = 0;

	conv3x3_valid_stream_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.pix_valid      (pix_valid),
		.pix_stall      (pix_stall),
		.pixel          (pixel),
		.start_of_image (start_of_image),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.conv_sum       (conv_sum),
		.last_of_image  (last_of_image),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Prints one line per mismatch, up to a cap, and counts them all.
	task automatic flag_mismatch(input string what);
		if (mismatch_count < MAX_PRINTED) begin
			$display("MISMATCH at %0d ns: %s", $time, what);
		end
		mismatch_count++;
	endtask

	// Takes one accepted pixel through the line stores and the window, and
	// queues the window sum once the window lies wholly inside the image.
	task automatic convolve_pixel(input logic [PIX_BITS-1:0] px, input logic sop);
		logic [PIX_BITS-1:0]         top;
		logic [PIX_BITS-1:0]         mid;
		logic signed [COEF_BITS-1:0] coef;
		longint                      acc;
		window_sum_t                 item;
		if (sop) begin
			col_pos = 0;
			row_pos = 0;
		end
		top = store_upper[col_pos];
		mid = store_lower[col_pos];
		for (int r = 0; r < 3; r++) begin
			window_px[r][0] = window_px[r][1];
			window_px[r][1] = window_px[r][2];
		end
		window_px[0][2] = top;
		window_px[1][2] = mid;
		window_px[2][2] = px;
		store_upper[col_pos] = mid;
		store_lower[col_pos] = px;
		if (row_pos >= 2 && col_pos >= 2) begin
			acc = 0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					coef = kernel_copy[r][c*COEF_BITS +: COEF_BITS];
					acc += longint'(window_px[r][c]) * longint'(coef);
				end
			end
			item.sum  = acc[SUM_BITS-1:0];
			item.last = (row_pos == IMG_H - 1) && (col_pos == IMG_W - 1);
			pending_sums = {pending_sums, item};
		end
		col_pos++;
		if (col_pos >= IMG_W) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= IMG_H) begin
				row_pos = 0;
			end
		end
	endtask

	// Pixel driver: a transfer happens when valid is high and stall is low.
	// New pixels are offered in bursts with random gaps between them.
	always @(posedge clk) begin : drive_pixels
		pixel_item_t fed;
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else begin
			if (pix_valid && !pix_stall) begin
				convolve_pixel(pixel, start_of_image);
				pixels_sent++;
			end
			if (pix_valid && pix_stall) begin
				input_stalls++;
			end
			if (!pix_valid || !pix_stall) begin
				if (gap_left > 0 && !steady_flow) begin
					gap_left--;
					pix_valid <= 1'b0;
				end else if (pixel_feed.size() != 0) begin
					fed = pixel_feed.pop_front();
					pixel          <= fed.value;
					start_of_image <= fed.sop;
					pix_valid      <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold, counted here so that the sender keeps going.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_served + 1;
			hold_left   <= LONG_HOLD_CYCLES;
		end
	end

	// Result monitor: checks each transfer against the oldest expected sum,
	// then picks the stall for the next cycle from free runs and stall runs.
	always @(posedge clk) begin : check_results
		window_sum_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (pending_sums.size() == 0) begin
					flag_mismatch($sformatf("result %0d with none expected", conv_sum));
				end else begin
					want = pending_sums.pop_front();
					results_seen++;
					if (conv_sum !== want.sum) begin
						flag_mismatch($sformatf("conv_sum %0d, expected %0d",
							conv_sum, $signed(want.sum)));
					end
					if (last_of_image !== want.last) begin
						flag_mismatch($sformatf("last_of_image %b, expected %b",
							last_of_image, want.last));
					end
				end
			end
			if (hold_left != 0) begin
				res_stall <= 1'b1;
			end else if (steady_flow) begin
				res_stall <= 1'b0;
			end else if (flow_left > 0) begin
				flow_left--;
				res_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else begin
				flow_left  = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
				                                         : $urandom_range(0, 12);
				stall_left = $urandom_range(1, 5);
				res_stall <= 1'b0;
			end
		end
	end

	// Shadow of the kernel registers, updated on each configuration transfer.
	always @(posedge clk) begin
		if (!arst_n) begin
			kernel_copy <= '{default: '0};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				conv3_pkg::REG_KERNEL_ROW_TOP: begin
					kernel_copy[0] <= cfg_data;
				end
				conv3_pkg::REG_KERNEL_ROW_MID: begin
					kernel_copy[1] <= cfg_data;
				end
				conv3_pkg::REG_KERNEL_ROW_BOTTOM: begin
					kernel_copy[2] <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	task automatic write_kernel_reg(input logic [conv3_pkg::CFG_INDEX_BITS-1:0] index,
		input logic [ROW_BITS-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_kernel(input logic [ROW_BITS-1:0] top,
		input logic [ROW_BITS-1:0] mid, input logic [ROW_BITS-1:0] bottom);
		write_kernel_reg(conv3_pkg::REG_KERNEL_ROW_TOP, top);
		write_kernel_reg(conv3_pkg::REG_KERNEL_ROW_MID, mid);
		write_kernel_reg(conv3_pkg::REG_KERNEL_ROW_BOTTOM, bottom);
	endtask

	function automatic logic [ROW_BITS-1:0] random_kernel_row();
		return {16'($urandom()), $urandom()};
	endfunction

	task automatic feed_one(input logic [PIX_BITS-1:0] value, input logic sop);
		pixel_item_t item;
		item.value = value;
		item.sop   = sop;
		pixel_feed = {pixel_feed, item};
	endtask

	// Queues a run of pixels; bright runs are mostly full scale with some black.
	task automatic feed_pixels(input int count, input logic first_sop, input px_mode_t mode);
		logic [PIX_BITS-1:0] v;
		@(negedge clk);
		for (int i = 0; i < count; i++) begin
			if (mode == PX_BRIGHT) begin
				v = ($urandom_range(0, 7) == 0) ? '0 : '1;
			end else begin
				v = PIX_BITS'($urandom_range(0, (1 << PIX_BITS) - 1));
			end
			feed_one(v, first_sop && (i == 0));
		end
	endtask

	// Waits until every pixel is taken and every sum has arrived, then lets the
	// pipeline empty of border pixels that give no result.
	task automatic wait_drained();
		do @(negedge clk); while (pixel_feed.size() != 0 || pix_valid || pending_sums.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin : run_regression
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Border pixels only: extremes, alternating bits and a restart mid-row.
		@(negedge clk);
		feed_one('0, 1'b1);
		feed_one('1, 1'b0);
		feed_one('0, 1'b0);
		feed_one('1, 1'b0);
		feed_one(8'h55, 1'b0);
		feed_one(8'haa, 1'b0);
		feed_one(8'h01, 1'b0);
		feed_one(8'h80, 1'b0);
		feed_one(8'hfe, 1'b0);
		feed_one(8'h7f, 1'b0);
		for (int i = 0; i < 10; i++) begin
			feed_one(PIX_BITS'($urandom_range(0, 255)), 1'b0);
		end
		feed_one('1, 1'b1);
		for (int i = 0; i < 4; i++) begin
			feed_one(PIX_BITS'($urandom_range(0, 255)), 1'b0);
		end
		wait_drained();

		// One full image split over four kernels, pausing to drain between them.
		// The first part runs into a long receiver hold.
		set_kernel({3{COEF_MOST_NEG}}, {3{COEF_MOST_NEG}}, {3{COEF_MOST_NEG}});
		@(negedge clk);
		hold_requests++;
		feed_pixels(230, 1'b1, PX_BRIGHT);
		wait_drained();

		set_kernel({3{COEF_MOST_POS}}, {3{COEF_MOST_POS}}, {3{COEF_MOST_POS}});
		feed_pixels(170, 1'b0, PX_BRIGHT);
		wait_drained();

		// No idling on either side for this part.
		set_kernel({3{COEF_MINUS_ONE}}, {3{COEF_MINUS_ONE}}, {3{COEF_MINUS_ONE}});
		steady_flow = 1'b1;
		feed_pixels(190, 1'b0, PX_RANDOM);
		wait_drained();
		steady_flow = 1'b0;

		set_kernel('0, '0, '0);
		feed_pixels(IMG_W * IMG_H - 590, 1'b0, PX_RANDOM);
		wait_drained();

		// Next image follows the wrap with no start mark, then a short broken
		// image and a fresh one; the unused index is written too.
		set_kernel(random_kernel_row(), random_kernel_row(), random_kernel_row());
		write_kernel_reg(CFG_INDEX_UNUSED, random_kernel_row());
		feed_pixels(3 * IMG_W + $urandom_range(2, 10), 1'b0, PX_RANDOM);
		feed_pixels($urandom_range(5, 15), 1'b1, PX_RANDOM);
		feed_pixels($urandom_range(60, 66), 1'b1, PX_RANDOM);
		wait_drained();

		$display("Run covered %0d pixels and %0d window sums over five kernel settings,",
			pixels_sent, results_seen);
		$display("a wrapped full image, mid-image restarts and %0d stalled pixel cycles.",
			input_stalls);
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin : watchdog
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/conv3_pkg.sv
design/conv3_ram.sv
design/conv3_window.sv
design/conv3_mac.sv
design/conv3x3_valid_stream_unit.sv
dv/tb.sv
